// ----- hw/rtl/sle_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared codes and the result word type of the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam logic [1:0] OP_GET    = 2'd0;
  localparam logic [1:0] OP_LOCATE = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic        status;
    logic [31:0] read_value;
    logic [8:0]  found_position;
    logic [8:0]  list_length;
    logic        list_empty;
  } sle_result_t;

endpackage

// ----- hw/rtl/sle_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_store
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sle_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/sle_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_seq
// Operation sequencer: holds the length, walks the store for locate and
// insert, and builds the result word.
// ----------------------------------------------------------------------------
module sle_seq #(
  parameter int DEPTH       = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               operation,
  input  logic [8:0]               position,
  input  logic [31:0]              value,
  input  logic                     res_free,
  output logic                     done,
  output sle_pkg::sle_result_t     result,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  logic [VALUE_WIDTH-1:0]   mem_rdata,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output logic [VALUE_WIDTH-1:0]   mem_wdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = CW + 10;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GET   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_LAST  = 3'd4;
  localparam logic [2:0] S_PUT   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]             state, state_next;
  logic [CW-1:0]          count, count_next;
  logic [CW-1:0]          idx, idx_next;
  logic [CW-1:0]          tgt, tgt_next;
  logic                   pend, pend_next;
  logic [CW-1:0]          pend_idx, pend_idx_next;
  logic [VALUE_WIDTH-1:0] val_q, val_q_next;
  logic [VALUE_WIDTH-1:0] rd_q, rd_q_next;
  logic [CW-1:0]          found, found_next;
  logic                   status, status_next;

  // Input decode, done in a width wide enough for both position and length
  logic [XW-1:0]          posx, cntx;
  logic [CW-1:0]          pos_m1, pend_inc;
  logic                   get_ok, ins_ok;
  logic [VALUE_WIDTH+31:0] val_ext, rd_ext;
  logic [CW+8:0]          found_ext, count_ext;

  assign posx     = XW'(position);
  assign cntx     = XW'(count);
  assign pos_m1   = CW'(posx - XW'(1));
  assign pend_inc = pend_idx + CW'(1);
  assign get_ok   = (position != 9'd0) && (posx <= cntx);
  assign ins_ok   = (position != 9'd0) && (posx <= cntx + XW'(1)) && (cntx < XW'(DEPTH));

  assign val_ext   = {{VALUE_WIDTH{1'b0}}, value};
  assign rd_ext    = {32'd0, rd_q};
  assign found_ext = {9'd0, found};
  assign count_ext = {9'd0, count};

  assign in_ready = (state == S_IDLE);
  assign done     = (state == S_FIN) && res_free;

  always_comb begin
    result.status         = status;
    result.read_value     = rd_ext[31:0];
    result.found_position = found_ext[8:0];
    result.list_length    = count_ext[8:0];
    result.list_empty     = (count == '0);
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    idx_next      = idx;
    tgt_next      = tgt;
    pend_next     = pend;
    pend_idx_next = pend_idx;
    val_q_next    = val_q;
    rd_q_next     = rd_q;
    found_next    = found;
    status_next   = status;
    mem_raddr     = idx[AW-1:0];
    mem_we        = 1'b0;
    mem_waddr     = pend_inc[AW-1:0];
    mem_wdata     = mem_rdata;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          pend_next   = 1'b0;
          status_next = sle_pkg::STATUS_OK;
          rd_q_next   = '0;
          found_next  = '0;
          val_q_next  = val_ext[VALUE_WIDTH-1:0];
          unique case (operation)
            sle_pkg::OP_GET: begin
              if (get_ok) begin
                mem_raddr  = pos_m1[AW-1:0];
                state_next = S_GET;
              end else begin
                status_next = sle_pkg::STATUS_ERR;
                state_next  = S_FIN;
              end
            end
            sle_pkg::OP_LOCATE: begin
              idx_next = '0;
              if (count == '0) begin
                state_next = S_FIN;
              end else begin
                state_next = S_SCAN;
              end
            end
            sle_pkg::OP_INSERT: begin
              if (ins_ok) begin
                count_next = count + CW'(1);
                tgt_next   = pos_m1;
                idx_next   = count - CW'(1);
                if (pos_m1 == count) begin
                  state_next = S_PUT;
                end else begin
                  state_next = S_SHIFT;
                end
              end else begin
                status_next = sle_pkg::STATUS_ERR;
                state_next  = S_FIN;
              end
            end
            sle_pkg::OP_CLEAR: begin
              count_next = '0;
              state_next = S_FIN;
            end
          endcase
        end
      end
      S_GET: begin
        rd_q_next  = mem_rdata;
        state_next = S_FIN;
      end
      S_SCAN: begin
        // read one entry a cycle, compare the one read in the cycle before
        pend_idx_next = idx;
        if (idx < count) begin
          idx_next  = idx + CW'(1);
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (pend) begin
          if (mem_rdata == val_q) begin
            found_next = pend_inc;
            state_next = S_FIN;
          end else if (pend_inc == count) begin
            state_next = S_FIN;
          end
        end
      end
      S_SHIFT: begin
        // descending read of entry idx, write-back of the previous one a slot up
        mem_we        = pend;
        pend_next     = 1'b1;
        pend_idx_next = idx;
        if (idx == tgt) begin
          state_next = S_LAST;
        end else begin
          idx_next = idx - CW'(1);
        end
      end
      S_LAST: begin
        mem_we     = 1'b1;
        state_next = S_PUT;
      end
      S_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = tgt[AW-1:0];
        mem_wdata  = val_q;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    tgt      <= tgt_next;
    pend_idx <= pend_idx_next;
    val_q    <= val_q_next;
    rd_q     <= rd_q_next;
    found    <= found_next;
    status   <= status_next;
  end

endmodule

// ----- hw/rtl/sequential_list_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine_core
// Ordered list of up to DEPTH entries kept in a single-port-pair store.
// ----------------------------------------------------------------------------
// One word is taken at a time and gives one result word. Clear and any
// rejected request go straight to the result; get reads one entry; locate
// scans from the first entry and stops at the first match or at the end of
// the list (no scan on an empty list); insert moves the entries from the
// last one down to the position one slot up, then writes the new value, and
// an append skips the moves. Locate and insert are paced by the store's
// single read and single write port: locate compares one entry a cycle and
// insert moves one entry a cycle. A new word is taken as soon as the
// sequencer is idle, even while the previous result still waits in the
// output register. Widths of position, found_position and list_length are
// 9 bits; with DEPTH above 511 the reported length and position wrap modulo
// 512. Values are kept to their low VALUE_WIDTH bits.
// ----------------------------------------------------------------------------
module sequential_list_engine_core #(
  parameter int DEPTH       = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [8:0]  position,
  input  logic [31:0] value,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [31:0] read_value,
  output logic [8:0]  found_position,
  output logic [8:0]  list_length,
  output logic        list_empty
);

  localparam int AW = $clog2(DEPTH);

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;

  logic                   seq_done;
  logic                   res_free;
  sle_pkg::sle_result_t   seq_result;
  sle_pkg::sle_result_t   res_q;

  // The output register is free when empty or being drained this cycle
  assign res_free = !out_valid || out_ready;

  sle_store #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sle_seq #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .position  (position),
    .value     (value),
    .res_free  (res_free),
    .done      (seq_done),
    .result    (seq_result),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  // Output register: decouples the sequencer from the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done) begin
      res_q <= seq_result;
    end
  end

  assign status         = res_q.status;
  assign read_value     = res_q.read_value;
  assign found_position = res_q.found_position;
  assign list_length    = res_q.list_length;
  assign list_empty     = res_q.list_empty;

endmodule

// ----- hw/rtl/sle_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks on the result channel of the sequential list engine.
// ----------------------------------------------------------------------------
module sle_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        status,
  input logic [31:0] read_value,
  input logic [8:0]  found_position,
  input logic [8:0]  list_length,
  input logic        list_empty
);

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(list_length))
    else $error("result word changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (list_empty == (list_length == 9'd0)))
    else $error("empty flag disagrees with length");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == sle_pkg::STATUS_ERR) |-> (read_value == 32'd0)
      && (found_position == 9'd0))
    else $error("failed request carries data");

  a_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && (found_position != 9'd0) |-> (status == sle_pkg::STATUS_OK)
      && (read_value == 32'd0) && !list_empty)
    else $error("match reported on inconsistent result");

endmodule

bind sequential_list_engine_core sle_checker u_sle_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .read_value     (read_value),
  .found_position (found_position),
  .list_length    (list_length),
  .list_empty     (list_empty)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sequential list engine.
// ----------------------------------------------------------------------------
// A short table of directed words comes first. Rows whose answer is obvious
// carry it inline. All other rows, and the random traffic after them, are
// checked against a shadow copy of the list kept in the bench. The random
// part fills the list to the brim, probes the full case, clears it, then
// runs mixed traffic under several patterns of sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIST_DEPTH    = 256;
  localparam int DIRECTED_ROWS = 25;
  localparam int DRAIN_CYCLES  = 300;   // longest insert or locate, with margin

  localparam logic FROM_TABLE = 1'b1;
  localparam logic PREDICTED  = 1'b0;
  localparam sle_pkg::sle_result_t NO_RESULT = '0;

  typedef struct packed {
    logic [1:0]           op;
    logic [8:0]           pos;
    logic [31:0]          val;
    logic                 from_table;
    sle_pkg::sle_result_t result;
  } plan_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = sle_pkg::OP_GET;
  logic [8:0]  position  = '0;
  logic [31:0] value     = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        status;
  logic [31:0] read_value;
  logic [8:0]  found_position;
  logic [8:0]  list_length;
  logic        list_empty;

  // shadow copy of the list
  logic [31:0] shadow_entries [0:LIST_DEPTH-1];
  int unsigned shadow_len = 0;

  sle_pkg::sle_result_t pending_results [$];
  sle_pkg::sle_result_t head_result;
  plan_row_t            directed_plan [0:DIRECTED_ROWS-1];

  int fail_count    = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  sequential_list_engine_core #(
    .DEPTH       (LIST_DEPTH),
    .VALUE_WIDTH (32)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .position       (position),
    .value          (value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .read_value     (read_value),
    .found_position (found_position),
    .list_length    (list_length),
    .list_empty     (list_empty)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Applies one word to the shadow list and returns the result it should give.
  function automatic sle_pkg::sle_result_t list_apply(input logic [1:0]  op,
                                                      input logic [8:0]  pos,
                                                      input logic [31:0] val);
    sle_pkg::sle_result_t r;
    int                   k;
    r = '0;
    case (op)
      sle_pkg::OP_GET: begin
        if (pos < 1 || pos > shadow_len)
          r.status = sle_pkg::STATUS_ERR;
        else
          r.read_value = shadow_entries[pos - 1];
      end
      sle_pkg::OP_LOCATE: begin
        for (k = 0; k < shadow_len; k++)
          if (r.found_position == 0 && shadow_entries[k] == val)
            r.found_position = 9'(k + 1);
      end
      sle_pkg::OP_INSERT: begin
        if (pos < 1 || pos > shadow_len + 1 || shadow_len >= LIST_DEPTH) begin
          r.status = sle_pkg::STATUS_ERR;
        end else begin
          for (k = shadow_len; k >= pos; k--)
            shadow_entries[k] = shadow_entries[k - 1];
          shadow_entries[pos - 1] = val;
          shadow_len++;
        end
      end
      default: shadow_len = 0;
    endcase
    r.list_length = shadow_len[8:0];
    r.list_empty  = (shadow_len == 0);
    return r;
  endfunction

  // Small values now and then, so that duplicates and first-match cases occur.
  function automatic logic [31:0] random_value();
    if ($urandom_range(99) < 25)
      return $urandom_range(0, 3);
    return $urandom;
  endfunction

  // Mostly a value already held, so that locate finds something.
  function automatic logic [31:0] lookup_value();
    if (shadow_len > 0 && $urandom_range(99) < 60)
      return shadow_entries[$urandom_range(0, shadow_len - 1)];
    return random_value();
  endfunction

  function automatic logic [8:0] held_position();
    if (shadow_len == 0)
      return 9'd1;
    return 9'($urandom_range(1, shadow_len));
  endfunction

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= 10)
      $display("%s", msg);
  endtask

  // Presents one word, holds it until taken, then records its expected result.
  task automatic issue_word(input logic [1:0] op, input logic [8:0] pos,
                            input logic [31:0] val, input logic from_table,
                            input sle_pkg::sle_result_t table_result);
    sle_pkg::sle_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    position  <= pos;
    value     <= val;
    do @(posedge clk); while (!in_ready);
    predicted = list_apply(op, pos, val);
    pending_results.push_back(from_table ? table_result : predicted);
  endtask

  task automatic issue_random_word();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40)
      issue_word(sle_pkg::OP_INSERT, 9'($urandom_range(1, shadow_len + 1)), random_value(),
                 PREDICTED, NO_RESULT);
    else if (roll < 60)
      issue_word(sle_pkg::OP_GET, held_position(), $urandom, PREDICTED, NO_RESULT);
    else if (roll < 85)
      issue_word(sle_pkg::OP_LOCATE, 9'($urandom_range(0, 511)), lookup_value(), PREDICTED,
                 NO_RESULT);
    else if (roll < 88)
      issue_word(sle_pkg::OP_CLEAR, 9'($urandom_range(0, 511)), $urandom, PREDICTED,
                 NO_RESULT);
    else
      // noise: anything the fields allow
      issue_word(2'($urandom_range(0, 3)), 9'($urandom_range(0, 511)), $urandom, PREDICTED,
                 NO_RESULT);
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_failure($sformatf(
          "unexpected result word: st %0d rd %h pos %0d len %0d empty %0d",
          status, read_value, found_position, list_length, list_empty));
      end else begin
        head_result = pending_results.pop_front();
        if (status !== head_result.status || read_value !== head_result.read_value ||
            found_position !== head_result.found_position ||
            list_length !== head_result.list_length ||
            list_empty !== head_result.list_empty)
          report_failure($sformatf(
            "exp st %0d rd %h pos %0d len %0d e %0d, got st %0d rd %h pos %0d len %0d e %0d",
            head_result.status, head_result.read_value, head_result.found_position,
            head_result.list_length, head_result.list_empty,
            status, read_value, found_position, list_length, list_empty));
      end
    end
  end

  initial begin : stimulus
    int unsigned roll;

    // op, position, value, source of answer, answer when typed in
    directed_plan[0]  = {sle_pkg::OP_GET,    9'd1,   32'h0,         FROM_TABLE,
                         sle_pkg::STATUS_ERR, 32'h0, 9'd0, 9'd0, 1'b1}; // get on empty list
    directed_plan[1]  = {sle_pkg::OP_LOCATE, 9'd0,   32'h0,         FROM_TABLE,
                         sle_pkg::STATUS_OK,  32'h0, 9'd0, 9'd0, 1'b1}; // locate on empty list
    directed_plan[2]  = {sle_pkg::OP_INSERT, 9'd0,   32'h1234,      FROM_TABLE,
                         sle_pkg::STATUS_ERR, 32'h0, 9'd0, 9'd0, 1'b1}; // position zero
    directed_plan[3]  = {sle_pkg::OP_INSERT, 9'd2,   32'h1234,      FROM_TABLE,
                         sle_pkg::STATUS_ERR, 32'h0, 9'd0, 9'd0, 1'b1}; // past length + 1
    directed_plan[4]  = {sle_pkg::OP_INSERT, 9'd1,   32'hFFFF_FFFF, FROM_TABLE,
                         sle_pkg::STATUS_OK,  32'h0, 9'd0, 9'd1, 1'b0}; // append to empty list
    directed_plan[5]  = {sle_pkg::OP_GET,    9'd1,   32'h0,         FROM_TABLE,
                         sle_pkg::STATUS_OK,  32'hFFFF_FFFF, 9'd0, 9'd1, 1'b0};
    directed_plan[6]  = {sle_pkg::OP_INSERT, 9'd1,   32'h0,         PREDICTED,
                         NO_RESULT};                                     // at head
    directed_plan[7]  = {sle_pkg::OP_INSERT, 9'd3,   32'hA5A5_5A5A, PREDICTED,
                         NO_RESULT};                                     // at end
    directed_plan[8]  = {sle_pkg::OP_INSERT, 9'd2,   32'h8000_0001, PREDICTED,
                         NO_RESULT};                                     // middle
    directed_plan[9]  = {sle_pkg::OP_INSERT, 9'd4,   32'h0,         PREDICTED,
                         NO_RESULT};                                     // duplicate
    directed_plan[10] = {sle_pkg::OP_GET,    9'd0,   32'h0,         FROM_TABLE,
                         sle_pkg::STATUS_ERR, 32'h0, 9'd0, 9'd5, 1'b0};
    directed_plan[11] = {sle_pkg::OP_GET,    9'd6,   32'h0,         FROM_TABLE,
                         sle_pkg::STATUS_ERR, 32'h0, 9'd0, 9'd5, 1'b0}; // one past the end
    directed_plan[12] = {sle_pkg::OP_GET,    9'd511, 32'hFFFF_FFFF, FROM_TABLE,
                         sle_pkg::STATUS_ERR, 32'h0, 9'd0, 9'd5, 1'b0};
    directed_plan[13] = {sle_pkg::OP_GET,    9'd5,   32'h0,         PREDICTED,
                         NO_RESULT};
    directed_plan[14] = {sle_pkg::OP_GET,    9'd1,   32'h0,         PREDICTED,
                         NO_RESULT};
    directed_plan[15] = {sle_pkg::OP_LOCATE, 9'd0,   32'h0,         PREDICTED,
                         NO_RESULT};                                     // first of two
    directed_plan[16] = {sle_pkg::OP_LOCATE, 9'd511, 32'hA5A5_5A5A, PREDICTED,
                         NO_RESULT};                                     // last entry
    directed_plan[17] = {sle_pkg::OP_LOCATE, 9'd3,   32'h1234_5678, PREDICTED,
                         NO_RESULT};                                     // no match
    directed_plan[18] = {sle_pkg::OP_INSERT, 9'd511, 32'h0,         FROM_TABLE,
                         sle_pkg::STATUS_ERR, 32'h0, 9'd0, 9'd5, 1'b0};
    directed_plan[19] = {sle_pkg::OP_INSERT, 9'd7,   32'h0,         FROM_TABLE,
                         sle_pkg::STATUS_ERR, 32'h0, 9'd0, 9'd5, 1'b0}; // length + 2
    directed_plan[20] = {sle_pkg::OP_INSERT, 9'd6,   32'h7FFF_FFFF, PREDICTED,
                         NO_RESULT};                                     // append
    directed_plan[21] = {sle_pkg::OP_CLEAR,  9'd511, 32'hFFFF_FFFF, FROM_TABLE,
                         sle_pkg::STATUS_OK,  32'h0, 9'd0, 9'd0, 1'b1};
    directed_plan[22] = {sle_pkg::OP_GET,    9'd1,   32'h0,         FROM_TABLE,
                         sle_pkg::STATUS_ERR, 32'h0, 9'd0, 9'd0, 1'b1}; // stale entry hidden
    directed_plan[23] = {sle_pkg::OP_LOCATE, 9'd0,   32'hFFFF_FFFF, FROM_TABLE,
                         sle_pkg::STATUS_OK,  32'h0, 9'd0, 9'd0, 1'b1};
    directed_plan[24] = {sle_pkg::OP_INSERT, 9'd1,   32'h5,         PREDICTED,
                         NO_RESULT};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++)
      issue_word(directed_plan[r].op, directed_plan[r].pos, directed_plan[r].val,
                 directed_plan[r].from_table, directed_plan[r].result);

    // fill to capacity with inserts at random places, reads mixed in
    while (shadow_len < LIST_DEPTH) begin
      roll = $urandom_range(99);
      if (roll < 75)
        issue_word(sle_pkg::OP_INSERT, 9'($urandom_range(1, shadow_len + 1)),
                   random_value(), PREDICTED, NO_RESULT);
      else if (roll < 85)
        issue_word(sle_pkg::OP_GET, held_position(), $urandom, PREDICTED, NO_RESULT);
      else
        issue_word(sle_pkg::OP_LOCATE, 9'($urandom_range(0, 511)), lookup_value(),
                   PREDICTED, NO_RESULT);
    end

    // full list: every insert must be refused
    issue_word(sle_pkg::OP_INSERT, 9'(LIST_DEPTH + 1), $urandom, PREDICTED, NO_RESULT);
    issue_word(sle_pkg::OP_INSERT, 9'd1, $urandom, PREDICTED, NO_RESULT);
    issue_word(sle_pkg::OP_INSERT, 9'($urandom_range(2, LIST_DEPTH)), $urandom, PREDICTED,
               NO_RESULT);
    issue_word(sle_pkg::OP_GET, 9'(LIST_DEPTH), 32'h0, PREDICTED, NO_RESULT);
    issue_word(sle_pkg::OP_GET, 9'(LIST_DEPTH + 1), 32'h0, PREDICTED, NO_RESULT);
    issue_word(sle_pkg::OP_LOCATE, 9'd0, shadow_entries[LIST_DEPTH - 1], PREDICTED,
               NO_RESULT);
    issue_word(sle_pkg::OP_LOCATE, 9'd0, $urandom, PREDICTED, NO_RESULT);
    issue_word(sle_pkg::OP_CLEAR, 9'($urandom_range(0, 511)), $urandom, PREDICTED,
               NO_RESULT);

    send_idle_pct = 50;
    stall_pct     = 0;
    repeat (80) issue_random_word();

    send_idle_pct = 0;
    stall_pct     = 50;
    repeat (80) issue_random_word();

    send_idle_pct = 12;
    stall_pct     = 12;
    repeat (80) issue_random_word();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
